@@ rtl/pwcm_pkg.sv @@
`timescale 1ns / 1ps
package pwcm_pkg;

	localparam int FIELD_W   = 13;
	localparam int REG_W     = 14;
	localparam int REG_IDX_W = 3;
	localparam int COEF_W    = 48;
	localparam int COEF_IDX_W = 4;
	localparam int NUM_COEFS = 9;
	localparam int CENT_W    = FIELD_W + 2;
	localparam int PROD_W    = COEF_W + CENT_W;
	localparam int SUM_W     = PROD_W + 1;
	localparam int MAG_W     = SUM_W - 1;
	localparam int QBITS     = FIELD_W + 2;
	localparam int POS_W     = QBITS + 3;
	localparam int FIELD_MAX = (1 << FIELD_W) - 1;

	localparam logic [REG_IDX_W-1:0] REG_SRC_W  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SRC_H  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_DST_W  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_DST_H  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ROI_XB = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_ROI_XL = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_ROI_YB = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_ROI_YL = 3'd7;

	localparam logic [REG_W-1:0] SIZE_RESET = 14'd8192;

	localparam logic REQ_MAP  = 1'b0;
	localparam logic REQ_COEF = 1'b1;

	// travels alongside the divider
	typedef struct packed {
		logic [FIELD_W-1:0] dx;
		logic [FIELD_W-1:0] dy;
		logic               neg_k;
		logic               neg_l;
		logic               m_zero;
	} pwcm_side_t;

	typedef struct packed {
		logic [QBITS-1:0] q;
		logic             rnz;
		logic             ovf;
	} pwcm_quo_t;

endpackage

@@ rtl/pwcm_req_if.sv @@
`timescale 1ns / 1ps
interface pwcm_req_if;
	import pwcm_pkg::*;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [COEF_IDX_W-1:0]        coef_index;
	logic signed [COEF_W-1:0]     coef_value;
	logic [FIELD_W-1:0]           dest_x;
	logic [FIELD_W-1:0]           dest_y;

	modport source(output valid, req_type, coef_index, coef_value, dest_x, dest_y,
		input ready);
	modport sink(input valid, req_type, coef_index, coef_value, dest_x, dest_y,
		output ready);
endinterface

@@ rtl/pwcm_res_if.sv @@
`timescale 1ns / 1ps
interface pwcm_res_if;
	import pwcm_pkg::*;
	logic               valid;
	logic               ready;
	logic [FIELD_W-1:0] src_x;
	logic [FIELD_W-1:0] src_y;
	logic               inside_res;
	logic [FIELD_W-1:0] out_x;
	logic [FIELD_W-1:0] out_y;

	modport source(output valid, src_x, src_y, inside_res, out_x, out_y, input ready);
	modport sink(input valid, src_x, src_y, inside_res, out_x, out_y, output ready);
endinterface

@@ rtl/pwcm_divider.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, two numerators over one divisor.
// One range check stage, then one quotient bit per stage, MSB first.
module pwcm_divider #(
	parameter int NW = pwcm_pkg::MAG_W,
	parameter int QB = pwcm_pkg::QBITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_v,
	input  logic [NW-1:0]        num_k,
	input  logic [NW-1:0]        num_l,
	input  logic [NW-1:0]        den,
	input  pwcm_pkg::pwcm_side_t in_side,
	output logic                 out_v,
	output pwcm_pkg::pwcm_quo_t  quo_k,
	output pwcm_pkg::pwcm_quo_t  quo_l,
	output pwcm_pkg::pwcm_side_t out_side
);
	import pwcm_pkg::*;

	localparam int XW = NW + QB;

	typedef struct packed {
		logic [NW-1:0] rk;
		logic [NW-1:0] rl;
		logic [NW-1:0] d;
		logic [QB-1:0] qk;
		logic [QB-1:0] ql;
		logic          ovk;
		logic          ovl;
		pwcm_side_t    side;
	} dstage_t;

	logic    v_s [0:QB];
	dstage_t d_s [0:QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_v;
		end
	end

	// quotient would need more than QB bits: result is out of any valid range
	always_ff @(posedge clk) begin
		if (en) begin
			d_s[0].rk   <= num_k;
			d_s[0].rl   <= num_l;
			d_s[0].d    <= den;
			d_s[0].qk   <= '0;
			d_s[0].ql   <= '0;
			d_s[0].ovk  <= {{QB{1'b0}}, num_k} >= {den, {QB{1'b0}}};
			d_s[0].ovl  <= {{QB{1'b0}}, num_l} >= {den, {QB{1'b0}}};
			d_s[0].side <= in_side;
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		localparam int B = QB - j;
		logic [XW-1:0] sh, xk, xl;
		logic          gk, gl;
		dstage_t       nx;

		always_comb begin
			sh = {{QB{1'b0}}, d_s[j-1].d} << B;
			xk = {{QB{1'b0}}, d_s[j-1].rk};
			xl = {{QB{1'b0}}, d_s[j-1].rl};
			gk = xk >= sh;
			gl = xl >= sh;
			nx = d_s[j-1];
			nx.qk[B] = gk;
			nx.ql[B] = gl;
			if (gk) begin
				nx.rk = NW'(xk - sh);
			end
			if (gl) begin
				nx.rl = NW'(xl - sh);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j] <= nx;
			end
		end
	end

	assign out_v      = v_s[QB];
	assign quo_k.q    = d_s[QB].qk;
	assign quo_k.rnz  = d_s[QB].rk != '0;
	assign quo_k.ovf  = d_s[QB].ovk;
	assign quo_l.q    = d_s[QB].ql;
	assign quo_l.rnz  = d_s[QB].rl != '0;
	assign quo_l.ovf  = d_s[QB].ovl;
	assign out_side   = d_s[QB].side;

endmodule

@@ rtl/perspective_warp_coordinate_map_core.sv @@
`timescale 1ns / 1ps
// Perspective warp coordinate mapper, nearest neighbor. Each map request
// takes one destination pixel through the 3x3 homography and returns the
// source pixel to copy or a zero-fill flag; coefficient-write requests and
// destination pixels outside the destination size return nothing. The
// block takes one request every cycle while the result is not stalled;
// each result passes through input, multiply, add, magnitude, a range
// check plus 15 restoring divider stages (one quotient bit each), a
// floor-and-offset stage and the fixup stage, which is also the output
// register. Backpressure stalls the whole pipeline in place.
// A coefficient write takes effect for every map request accepted after it.
module perspective_warp_coordinate_map_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pwcm_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [pwcm_pkg::REG_W-1:0]     cfg_wdata,
	pwcm_req_if.sink                      req,
	pwcm_res_if.source                    res
);
	import pwcm_pkg::*;

	logic [REG_W-1:0] src_w_q, src_h_q, dst_w_q, dst_h_q;
	logic [REG_W-1:0] roi_xb_q, roi_xl_q, roi_yb_q, roi_yl_q;
	logic signed [COEF_W-1:0] coef_q [0:NUM_COEFS-1];

	logic en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= SIZE_RESET;
			src_h_q  <= SIZE_RESET;
			dst_w_q  <= SIZE_RESET;
			dst_h_q  <= SIZE_RESET;
			roi_xb_q <= '0;
			roi_xl_q <= SIZE_RESET;
			roi_yb_q <= '0;
			roi_yl_q <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SRC_W:  src_w_q  <= cfg_wdata;
				REG_SRC_H:  src_h_q  <= cfg_wdata;
				REG_DST_W:  dst_w_q  <= cfg_wdata;
				REG_DST_H:  dst_h_q  <= cfg_wdata;
				REG_ROI_XB: roi_xb_q <= cfg_wdata;
				REG_ROI_XL: roi_xl_q <= cfg_wdata;
				REG_ROI_YB: roi_yb_q <= cfg_wdata;
				REG_ROI_YL: roi_yl_q <= cfg_wdata;
			endcase
		end
	end

	// ---- s1: input register, centering, bounds
	logic                      v_s1, type_s1, inb_s1;
	logic [COEF_IDX_W-1:0]     idx_s1;
	logic signed [COEF_W-1:0]  coef_s1;
	logic [FIELD_W-1:0]        dx_s1, dy_s1;
	logic signed [CENT_W-1:0]  xc_s1, yc_s1;
	logic                      map_s1, wr_s1;

	assign req.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			type_s1 <= req.req_type;
			idx_s1  <= req.coef_index;
			coef_s1 <= req.coef_value;
			dx_s1   <= req.dest_x;
			dy_s1   <= req.dest_y;
			inb_s1  <= ({1'b0, req.dest_x} < dst_w_q) && ({1'b0, req.dest_y} < dst_h_q);
			xc_s1   <= $signed({2'b00, req.dest_x}) - $signed({2'b00, dst_w_q[REG_W-1:1]});
			yc_s1   <= $signed({2'b00, req.dest_y}) - $signed({2'b00, dst_h_q[REG_W-1:1]});
		end
	end

	assign map_s1 = v_s1 && (type_s1 == REQ_MAP) && inb_s1;
	assign wr_s1  = v_s1 && (type_s1 == REQ_COEF);

	// coefficient writes commit in request order as they leave s1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (en && wr_s1 && (idx_s1 < COEF_IDX_W'(NUM_COEFS))) begin
			coef_q[idx_s1] <= coef_s1;
		end
	end

	// ---- s2: products
	logic                      v_s2;
	logic signed [PROD_W-1:0]  prod_s2 [0:5];
	logic signed [COEF_W-1:0]  cst_s2  [0:2];
	logic [FIELD_W-1:0]        dx_s2, dy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= map_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				prod_s2[2*r]   <= PROD_W'(coef_q[3*r] * xc_s1);
				prod_s2[2*r+1] <= PROD_W'(coef_q[3*r+1] * yc_s1);
				cst_s2[r]      <= coef_q[3*r+2];
			end
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
		end
	end

	// ---- s3: dot products
	logic                     v_s3;
	logic signed [SUM_W-1:0]  sum_s3 [0:2];
	logic [FIELD_W-1:0]       dx_s3, dy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				sum_s3[r] <= SUM_W'(prod_s2[2*r]) + SUM_W'(prod_s2[2*r+1]) + SUM_W'(cst_s2[r]);
			end
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
		end
	end

	// ---- s4: magnitudes and quotient signs
	logic               v_s4;
	logic [MAG_W-1:0]   mag_s4 [0:2];
	pwcm_side_t         side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				mag_s4[r] <= sum_s3[r][SUM_W-1] ? MAG_W'(-sum_s3[r]) : MAG_W'(sum_s3[r]);
			end
			side_s4.dx     <= dx_s3;
			side_s4.dy     <= dy_s3;
			side_s4.neg_k  <= sum_s3[0][SUM_W-1] ^ sum_s3[2][SUM_W-1];
			side_s4.neg_l  <= sum_s3[1][SUM_W-1] ^ sum_s3[2][SUM_W-1];
			side_s4.m_zero <= sum_s3[2] == '0;
		end
	end

	// ---- divider
	logic       dv;
	pwcm_quo_t  qk, ql;
	pwcm_side_t dside;

	pwcm_divider #(
		.NW(MAG_W),
		.QB(QBITS)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_v    (v_s4),
		.num_k   (mag_s4[0]),
		.num_l   (mag_s4[1]),
		.den     (mag_s4[2]),
		.in_side (side_s4),
		.out_v   (dv),
		.quo_k   (qk),
		.quo_l   (ql),
		.out_side(dside)
	);

	// floor(num/den) + half, before the truncate-toward-zero fixup
	function automatic logic signed [POS_W-1:0] floor_add(pwcm_quo_t qo, logic neg,
		logic [REG_W-1:0] size);
		logic [QBITS:0]          mag;
		logic signed [POS_W-1:0] fq;
		mag = {1'b0, qo.q} + ((neg && qo.rnz) ? (QBITS+1)'(1) : (QBITS+1)'(0));
		fq  = neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
		return fq + $signed({{(POS_W-REG_W+1){1'b0}}, size[REG_W-1:1]});
	endfunction

	// ---- s5
	logic                    v_s5, m_zero_s5;
	logic signed [POS_W-1:0] sx_s5, sy_s5;
	logic                    rnzx_s5, rnzy_s5, ovx_s5, ovy_s5;
	logic [FIELD_W-1:0]      dx_s5, dy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= dv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5     <= floor_add(qk, dside.neg_k, src_w_q);
			sy_s5     <= floor_add(ql, dside.neg_l, src_h_q);
			rnzx_s5   <= qk.rnz;
			rnzy_s5   <= ql.rnz;
			ovx_s5    <= qk.ovf;
			ovy_s5    <= ql.ovf;
			m_zero_s5 <= dside.m_zero;
			dx_s5     <= dside.dx;
			dy_s5     <= dside.dy;
		end
	end

	// ---- s6: fixup, ROI, output register
	logic signed [POS_W-1:0] sxc, syc;
	logic                    okx, oky, hit;

	always_comb begin
		sxc = (sx_s5 < 0 && rnzx_s5) ? sx_s5 + POS_W'(1) : sx_s5;
		syc = (sy_s5 < 0 && rnzy_s5) ? sy_s5 + POS_W'(1) : sy_s5;
		okx = !ovx_s5 && sxc >= 0 && sxc <= POS_W'(FIELD_MAX)
			&& sxc >= $signed({{(POS_W-REG_W){1'b0}}, roi_xb_q})
			&& sxc <  $signed({{(POS_W-REG_W){1'b0}}, roi_xl_q});
		oky = !ovy_s5 && syc >= 0 && syc <= POS_W'(FIELD_MAX)
			&& syc >= $signed({{(POS_W-REG_W){1'b0}}, roi_yb_q})
			&& syc <  $signed({{(POS_W-REG_W){1'b0}}, roi_yl_q});
		hit = !m_zero_s5 && okx && oky;
	end

	logic               res_v_s6, inside_s6;
	logic [FIELD_W-1:0] sx_s6, sy_s6, ox_s6, oy_s6;

	assign en = !res_v_s6 || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_s6 <= 1'b0;
		end else if (en) begin
			res_v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s6 <= hit;
			sx_s6     <= hit ? FIELD_W'(sxc) : '0;
			sy_s6     <= hit ? FIELD_W'(syc) : '0;
			ox_s6     <= dx_s5;
			oy_s6     <= dy_s5;
		end
	end

	assign res.valid      = res_v_s6;
	assign res.inside_res = inside_s6;
	assign res.src_x      = sx_s6;
	assign res.src_y      = sy_s6;
	assign res.out_x      = ox_s6;
	assign res.out_y      = oy_s6;

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |-> !req.ready)
		else $error("request taken while result stalled");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.inside_res |-> res.src_x == '0 && res.src_y == '0)
		else $error("zero fill with nonzero source");

	a_roi: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.inside_res |-> {1'b0, res.src_x} >= roi_xb_q
		&& {1'b0, res.src_x} < roi_xl_q && {1'b0, res.src_y} >= roi_yb_q
		&& {1'b0, res.src_y} < roi_yl_q)
		else $error("inside result outside ROI");

endmodule

@@ sim/tb_perspective_warp_coordinate_map_core.sv @@
`timescale 1ns / 1ps
module tb_perspective_warp_coordinate_map_core;
	import pwcm_pkg::*;

	localparam longint ONE_Q32 = 64'h1_0000_0000;
	localparam int TIMEOUT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int STALL_CYCLES = 300;

	typedef enum int {H_IDENTITY, H_NEAR, H_NOISE, H_FLAT} homography_kind_t;

	typedef struct {
		logic               kind;
		logic [COEF_IDX_W-1:0] idx;
		logic [COEF_W-1:0]  val;
		logic [FIELD_W-1:0] x;
		logic [FIELD_W-1:0] y;
	} warp_req_t;

	typedef struct {
		logic [FIELD_W-1:0] sx;
		logic [FIELD_W-1:0] sy;
		logic               hit;
		logic [FIELD_W-1:0] ox;
		logic [FIELD_W-1:0] oy;
	} warp_res_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_wdata;

	pwcm_req_if req_ch();
	pwcm_res_if res_ch();

	perspective_warp_coordinate_map_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req(req_ch),
		.res(res_ch)
	);

	warp_req_t pending_reqs[$];
	warp_res_t expected_maps[$];
	longint homography[NUM_COEFS];
	int src_w, src_h, dst_w, dst_h, roi_xb, roi_xl, roi_yb, roi_yl;
	int mismatches;
	int cycles;
	bit calm;
	bit stall_ask;
	int stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("perspective_warp_coordinate_map_core: mismatch");
			$finish;
		end
	end

	// exact trunc(num/den + half)
	function automatic longint div_add_trunc(input longint num, input longint den,
		input longint half);
		longint q, r, s;
		q = num / den;
		r = num - q * den;
		if (r != 0 && ((r < 0) != (den < 0)))
			q = q - 1;
		s = q + half;
		if (s < 0 && r != 0)
			s = s + 1;
		return s;
	endfunction

	function automatic bit warp_pixel(input logic [FIELD_W-1:0] x,
		input logic [FIELD_W-1:0] y, output warp_res_t r);
		longint xc, yc, k, l, m, sx, sy;
		bit in_roi;
		r.sx = '0;
		r.sy = '0;
		r.hit = 1'b0;
		r.ox = x;
		r.oy = y;
		if (int'(x) >= dst_w || int'(y) >= dst_h)
			return 1'b0;
		xc = longint'(x) - longint'(dst_w >> 1);
		yc = longint'(y) - longint'(dst_h >> 1);
		k = homography[0] * xc + homography[1] * yc + homography[2];
		l = homography[3] * xc + homography[4] * yc + homography[5];
		m = homography[6] * xc + homography[7] * yc + homography[8];
		if (m != 0) begin
			sx = div_add_trunc(k, m, longint'(src_w >> 1));
			sy = div_add_trunc(l, m, longint'(src_h >> 1));
			in_roi = sx >= roi_xb && sx < roi_xl && sy >= roi_yb && sy < roi_yl
				&& sx >= 0 && sx <= FIELD_MAX && sy >= 0 && sy <= FIELD_MAX;
			if (in_roi) begin
				r.sx = sx[FIELD_W-1:0];
				r.sy = sy[FIELD_W-1:0];
				r.hit = 1'b1;
			end
		end
		return 1'b1;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		warp_req_t r;
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_MAP;
			req_ch.coef_index <= '0;
			req_ch.coef_value <= '0;
			req_ch.dest_x <= '0;
			req_ch.dest_y <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= 26)) begin
				r = pending_reqs.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.req_type <= r.kind;
				req_ch.coef_index <= r.idx;
				req_ch.coef_value <= r.val;
				req_ch.dest_x <= r.x;
				req_ch.dest_y <= r.y;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			stall_left <= 0;
		else if (stall_ask)
			stall_left <= STALL_CYCLES;
		else if (stall_left != 0)
			stall_left <= stall_left - 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ch.ready <= 1'b0;
		else
			res_ch.ready <= !stall_ask && stall_left == 0
				&& (calm || $urandom_range(99) >= 26);
	end

	// accepted requests feed the predictor, results are checked in order
	always @(posedge clk) begin
		warp_res_t e, got;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				if (req_ch.req_type == REQ_COEF) begin
					if (req_ch.coef_index < NUM_COEFS)
						homography[req_ch.coef_index] =
							{{(64-COEF_W){req_ch.coef_value[COEF_W-1]}}, req_ch.coef_value};
				end else if (warp_pixel(req_ch.dest_x, req_ch.dest_y, e)) begin
					expected_maps.push_back(e);
				end
			end
			if (res_ch.valid && res_ch.ready) begin
				got.sx = res_ch.src_x;
				got.sy = res_ch.src_y;
				got.hit = res_ch.inside_res;
				got.ox = res_ch.out_x;
				got.oy = res_ch.out_y;
				if (expected_maps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: src %0d,%0d inside %0b dest %0d,%0d",
							got.sx, got.sy, got.hit, got.ox, got.oy);
				end else begin
					e = expected_maps.pop_front();
					if (got.sx !== e.sx || got.sy !== e.sy || got.hit !== e.hit
						|| got.ox !== e.ox || got.oy !== e.oy) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"dest %0d,%0d: expected src %0d,%0d in %0b ",
								"dest %0d,%0d, got src %0d,%0d in %0b dest %0d,%0d"},
								e.ox, e.oy, e.sx, e.sy, e.hit, e.ox, e.oy,
								got.sx, got.sy, got.hit, got.ox, got.oy);
					end
				end
			end
		end
	end

	task automatic push_coef(input int idx, input longint v);
		warp_req_t r;
		r.kind = REQ_COEF;
		r.idx = idx[COEF_IDX_W-1:0];
		r.val = v[COEF_W-1:0];
		r.x = FIELD_W'($urandom);
		r.y = FIELD_W'($urandom);
		pending_reqs.push_back(r);
	endtask

	task automatic push_map(input int x, input int y);
		warp_req_t r;
		r.kind = REQ_MAP;
		r.idx = COEF_IDX_W'($urandom);
		r.val = {$urandom, $urandom};
		r.x = x[FIELD_W-1:0];
		r.y = y[FIELD_W-1:0];
		pending_reqs.push_back(r);
	endtask

	function automatic longint srand_bits(input int bits);
		longint v;
		v = {$urandom, $urandom};
		return v >>> (63 - bits);
	endfunction

	task automatic load_homography(input homography_kind_t kind);
		for (int i = 0; i < NUM_COEFS; i++) begin
			longint v;
			case (kind)
				H_IDENTITY: v = (i % 4 == 0) ? ONE_Q32 : 0;
				H_FLAT: v = (i < 6) ? srand_bits(40) : 0;
				H_NOISE: v = {$urandom, $urandom};
				default: begin
					if (i % 4 == 0)
						v = ONE_Q32 + srand_bits(29);
					else if (i == 2 || i == 5)
						v = srand_bits(42);
					else if (i >= 6)
						v = srand_bits(17);
					else
						v = srand_bits(29);
				end
			endcase
			push_coef(i, v);
		end
	endtask

	task automatic push_maps(input int n);
		repeat (n) begin
			if ($urandom_range(9) == 0)
				push_map($urandom_range(8191), $urandom_range(8191));
			else
				push_map($urandom_range(dst_w - 1), $urandom_range(dst_h - 1));
		end
	endtask

	// block must be idle: nothing queued, nothing in flight
	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || req_ch.valid || expected_maps.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input int sw, input int sh, input int dw, input int dh,
		input int xb, input int xl, input int yb, input int yl);
		logic [REG_IDX_W-1:0] idx [8];
		int vals [8];
		idx = '{REG_SRC_W, REG_SRC_H, REG_DST_W, REG_DST_H,
			REG_ROI_XB, REG_ROI_XL, REG_ROI_YB, REG_ROI_YL};
		vals = '{sw, sh, dw, dh, xb, xl, yb, yl};
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= vals[i][REG_W-1:0];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		src_w = sw;
		src_h = sh;
		dst_w = dw;
		dst_h = dh;
		roi_xb = xb;
		roi_xl = xl;
		roi_yb = yb;
		roi_yl = yl;
	endtask

	task automatic random_regs();
		int sw, sh, dw, dh;
		sw = $urandom_range(3) == 0 ? 8192 : $urandom_range(16, 8192);
		sh = $urandom_range(3) == 0 ? 8192 : $urandom_range(16, 8192);
		dw = $urandom_range(3) == 0 ? 8192 : $urandom_range(1, 8192);
		dh = $urandom_range(3) == 0 ? 8192 : $urandom_range(1, 8192);
		write_regs(sw, sh, dw, dh, $urandom_range(sw / 2), $urandom_range(sw / 2, 8192),
			$urandom_range(sh / 2), $urandom_range(sh / 2, 8192));
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		calm = 1'b0;
		stall_ask = 1'b0;
		foreach (homography[i])
			homography[i] = 0;
		src_w = SIZE_RESET;
		src_h = SIZE_RESET;
		dst_w = SIZE_RESET;
		dst_h = SIZE_RESET;
		roi_xb = 0;
		roi_xl = SIZE_RESET;
		roi_yb = 0;
		roi_yl = SIZE_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset state: all-zero homography gives a zero divisor
		push_map(0, 0);
		push_map(8191, 8191);
		load_homography(H_IDENTITY);
		push_map(0, 0);
		push_map(8191, 8191);
		push_map(4096, 100);
		// out-of-range slot is dropped
		push_coef(15, 0);
		push_coef(9, ONE_Q32);
		push_map(17, 8000);
		push_coef(0, -(64'sd1 <<< 47));
		push_coef(4, (64'sd1 <<< 47) - 1);
		push_map(8191, 0);
		push_map(0, 8191);
		load_homography(H_IDENTITY);
		wait_idle();

		// extremes: single-pixel images, then an empty ROI
		write_regs(1, 1, 1, 1, 0, 8192, 0, 8192);
		push_map(0, 0);
		push_map(1, 0);
		push_map(0, 8191);
		wait_idle();
		write_regs(8192, 8192, 8192, 8192, 8192, 0, 8192, 0);
		push_map(4096, 4096);
		push_map(0, 0);
		wait_idle();

		for (int phase = 0; phase < 7; phase++) begin
			random_regs();
			calm = (phase == 2);
			if (phase == 6)
				load_homography(H_FLAT);
			else
				load_homography($urandom_range(3) == 0 ? H_NOISE : H_NEAR);
			if (phase == 3) begin
				// long output hold-off while requests keep coming
				@(posedge clk);
				stall_ask <= 1'b1;
				@(posedge clk);
				stall_ask <= 1'b0;
			end
			push_maps(30);
			if (phase == 4)
				load_homography(H_NEAR);
			push_maps(30);
			wait_idle();
		end

		if (mismatches == 0 && expected_maps.size() == 0)
			$display("perspective_warp_coordinate_map_core: match");
		else
			$display("perspective_warp_coordinate_map_core: mismatch");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/pwcm_pkg.sv
rtl/pwcm_req_if.sv
rtl/pwcm_res_if.sv
rtl/pwcm_divider.sv
rtl/perspective_warp_coordinate_map_core.sv
sim/tb_perspective_warp_coordinate_map_core.sv
